// ----- src/md5_pkg.sv -----
// ----------------------------------------------------------------------------
// MD5 package
// Shared types, initial chaining values and per-round tables for the MD5
// digest block.
// ----------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

  // Input kind codes carried on the slave-side tuser.
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // Message block geometry: sixteen 32-bit words.
  localparam int unsigned BLK_WORDS = 16;
  localparam int unsigned WADDR_W   = 4;

  // Highest byte count at which the pad byte and the length field still fit.
  localparam logic [5:0] LEN_LIMIT = 6'd55;

  // First pad byte and the word slots that hold the bit length.
  localparam logic [7:0]         PAD_BYTE  = 8'h80;
  localparam logic [WADDR_W-1:0] LEN_LO_IX = 4'd14;
  localparam logic [WADDR_W-1:0] LEN_HI_IX = 4'd15;

  // Initial chaining words; entry 0 is A.
  localparam logic [3:0][31:0] MD5_IV = {
    32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  // Working words A, B, C, D of one compression.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_abcd_t;

  // Additive constant of each round.
  function automatic logic [31:0] round_k(input logic [5:0] rnd);
    logic [31:0] k;
    case (rnd)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Left-rotate amount, chosen by round group and the round's low two bits.
  function automatic logic [4:0] round_s(input logic [5:0] rnd);
    logic [4:0] s;
    case ({rnd[5:4], rnd[1:0]})
      4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
      4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
      4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
      4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word used by a round; all sums wrap at sixteen words.
  function automatic logic [WADDR_W-1:0] msg_idx(input logic [5:0] rnd);
    logic [WADDR_W-1:0] i4;
    logic [WADDR_W-1:0] ix;
    i4 = rnd[3:0];
    case (rnd[5:4])
      2'd0:    ix = i4;
      2'd1:    ix = WADDR_W'(i4 * 4'd5 + 4'd1);
      2'd2:    ix = WADDR_W'(i4 * 4'd3 + 4'd5);
      default: ix = WADDR_W'(i4 * 4'd7);
    endcase
    return ix;
  endfunction

endpackage

`default_nettype wire

// ----- src/md5_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read share one clock edge.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- src/md5_round.sv -----
// ----------------------------------------------------------------------------
// MD5 round unit
// One compression round: boolean function, four-operand add, rotate and the
// final add, applied to the working words.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_round (
  input  wire md5_pkg::md5_abcd_t st_i,
  input  wire logic [31:0]        w_i,
  input  wire logic [5:0]         rnd_i,
  output      md5_pkg::md5_abcd_t st_o
);

  import md5_pkg::*;

  logic [31:0] f;
  logic [31:0] t;
  logic [4:0]  s;
  logic [31:0] rot;

  // Boolean function of the round group.
  always_comb begin
    case (rnd_i[5:4])
      2'd0:    f = (st_i.b & st_i.c) | (~st_i.b & st_i.d);
      2'd1:    f = (st_i.b & st_i.d) | (st_i.c & ~st_i.d);
      2'd2:    f = st_i.b ^ st_i.c ^ st_i.d;
      default: f = st_i.c ^ (st_i.b | ~st_i.d);
    endcase
  end

  // Sum, rotate and fold into B; the other words move down one place.
  assign t   = st_i.a + f + w_i + round_k(rnd_i);
  assign s   = round_s(rnd_i);
  assign rot = (t << s) | (t >> (6'd32 - {1'b0, s}));

  always_comb begin
    st_o.a = st_i.d;
    st_o.b = st_i.b + rot;
    st_o.c = st_i.b;
    st_o.d = st_i.c;
  end

endmodule

`default_nettype wire

// ----- src/md5_message_digest.sv -----
// ----------------------------------------------------------------------------
// MD5 message digest
// Hashes a byte stream and returns the four 32-bit digest words.
// ----------------------------------------------------------------------------
// Usage:
//   The slave-side channel carries one item per transfer. tuser = 0 appends
//   the byte on tdata; tuser = 1 ends the message, and tdata is ignored.
//   The master-side channel returns four transfers per message: words A, B,
//   C and D on tdata (digest bytes least significant first), the word number
//   on tuser and tlast on D.
//   Timing: the 64th byte of a block starts a compression (a read set-up
//   step, 64 rounds on the shared round unit at one round per cycle, a
//   fold into the chaining words), during which tready is low. A finish
//   item writes the pad words at one word per cycle, 1 to 16 words, then
//   compresses; when the length does not fit, a second 16-word pad and a
//   second compression follow. The digest transfers start after that, one
//   per cycle at best.
//   The block buffer is a 16 x 32 RAM with one write and one read port.
//   Stalls: while digest words wait on tready, no input is taken; the words
//   hold until transferred. After word D the chaining words and the byte
//   count return to their initial values and input resumes.
//   Reset: returns to idle with the initial chaining words and a zero count.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_message_digest (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] kind
  // Digest stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output      logic [1:0]  m_axis_tuser,   // [1:0] word_index
  output      logic        m_axis_tlast    // last_word
);

  import md5_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_e;

  state_e             state_q, state_d;
  logic [3:0][31:0]   chain_q, chain_d;
  logic [60:0]        count_q, count_d;
  logic [31:0]        part_q, part_d;
  md5_abcd_t          work_q, work_d;
  logic [5:0]         rnd_q, rnd_d;
  logic [WADDR_W-1:0] pad_addr_q, pad_addr_d;
  logic               pad_first_q, pad_first_d;
  logic               pad_len_q, pad_len_d;
  logic               fin_q, fin_d;
  logic [1:0]         oidx_q, oidx_d;

  logic               in_xfer;
  logic               out_xfer;
  logic               ram_we;
  logic [WADDR_W-1:0] ram_waddr;
  logic [31:0]        ram_wdata;
  logic [WADDR_W-1:0] ram_raddr;
  logic [31:0]        ram_rdata;
  logic [31:0]        first_word;
  logic [63:0]        bit_len;
  md5_abcd_t          round_out;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign bit_len  = {count_q, 3'b000};

  // Block buffer, one 32-bit little-endian word per entry.
  md5_ram #(
    .WIDTH (32),
    .DEPTH (BLK_WORDS)
  ) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared round unit.
  md5_round u_round (
    .st_i  (work_q),
    .w_i   (ram_rdata),
    .rnd_i (rnd_q),
    .st_o  (round_out)
  );

  // First pad word: bytes already held, then 0x80, then zeros.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (2'(j) < count_q[1:0]) begin
        first_word[8*j +: 8] = part_q[8*j +: 8];
      end else if (2'(j) == count_q[1:0]) begin
        first_word[8*j +: 8] = PAD_BYTE;
      end else begin
        first_word[8*j +: 8] = 8'h00;
      end
    end
  end

  // Sequencer: byte intake, padding, rounds, fold and digest output.
  always_comb begin
    state_d     = state_q;
    chain_d     = chain_q;
    count_d     = count_q;
    part_d      = part_q;
    work_d      = work_q;
    rnd_d       = rnd_q;
    pad_addr_d  = pad_addr_q;
    pad_first_d = pad_first_q;
    pad_len_d   = pad_len_q;
    fin_d       = fin_q;
    oidx_d      = oidx_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[5:2];
    ram_wdata   = {s_axis_tdata, part_q[23:0]};
    ram_raddr   = msg_idx(6'(rnd_q + 6'd1));

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (s_axis_tuser == KIND_BYTE) begin
            part_d[8*count_q[1:0] +: 8] = s_axis_tdata;
            count_d = count_q + 61'd1;
            ram_we  = (count_q[1:0] == 2'd3);
            fin_d   = 1'b0;
            if (count_q[5:0] == 6'd63) begin
              state_d = ST_LOAD;
            end
          end else begin
            fin_d       = 1'b1;
            pad_addr_d  = count_q[5:2];
            pad_first_d = 1'b1;
            pad_len_d   = (count_q[5:0] <= LEN_LIMIT);
            state_d     = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        ram_we    = 1'b1;
        ram_waddr = pad_addr_q;
        ram_wdata = pad_first_q ? first_word : 32'h0;
        if (pad_len_q && (pad_addr_q == LEN_LO_IX)) begin
          ram_wdata = bit_len[31:0];
        end else if (pad_len_q && (pad_addr_q == LEN_HI_IX)) begin
          ram_wdata = bit_len[63:32];
        end
        pad_first_d = 1'b0;
        pad_addr_d  = pad_addr_q + 4'd1;
        if (pad_addr_q == LEN_HI_IX) begin
          state_d = ST_LOAD;
        end
      end

      ST_LOAD: begin
        // Set up the read of the first round's word.
        ram_raddr = msg_idx(6'd0);
        work_d.a  = chain_q[0];
        work_d.b  = chain_q[1];
        work_d.c  = chain_q[2];
        work_d.d  = chain_q[3];
        rnd_d     = 6'd0;
        state_d   = ST_ROUND;
      end

      ST_ROUND: begin
        work_d = round_out;
        rnd_d  = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = ST_FOLD;
        end
      end

      ST_FOLD: begin
        chain_d[0] = chain_q[0] + work_q.a;
        chain_d[1] = chain_q[1] + work_q.b;
        chain_d[2] = chain_q[2] + work_q.c;
        chain_d[3] = chain_q[3] + work_q.d;
        if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (pad_len_q) begin
          oidx_d  = 2'd0;
          state_d = ST_OUT;
        end else begin
          // Length did not fit: one more block of zeros and the length.
          pad_addr_d  = '0;
          pad_first_d = 1'b0;
          pad_len_d   = 1'b1;
          state_d     = ST_PAD;
        end
      end

      ST_OUT: begin
        if (out_xfer) begin
          oidx_d = oidx_q + 2'd1;
          if (oidx_q == 2'd3) begin
            chain_d = MD5_IV;
            count_d = '0;
            fin_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chain_q     <= MD5_IV;
      count_q     <= '0;
      rnd_q       <= '0;
      pad_addr_q  <= '0;
      pad_first_q <= 1'b0;
      pad_len_q   <= 1'b0;
      fin_q       <= 1'b0;
      oidx_q      <= '0;
    end else begin
      state_q     <= state_d;
      chain_q     <= chain_d;
      count_q     <= count_d;
      rnd_q       <= rnd_d;
      pad_addr_q  <= pad_addr_d;
      pad_first_q <= pad_first_d;
      pad_len_q   <= pad_len_d;
      fin_q       <= fin_d;
      oidx_q      <= oidx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    work_q <= work_d;
  end

  // Port drive, all from registers.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = chain_q[oidx_q];
  assign m_axis_tuser  = oidx_q;
  assign m_axis_tlast  = (oidx_q == 2'd3);

  // The block never takes input while digest words are pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while digest pending");

  // A finish transfer always stalls the input for the padding.
  a_finish_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_FINISH))
      |=> !s_axis_tready)
    else $error("input ready right after finish");

  // The last round is followed by the fold.
  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && rnd_q == 6'd63) |=> (state_q == ST_FOLD))
    else $error("round sequence did not end in fold");

  // After word D the block is idle with a cleared count.
  a_digest_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast)
      |=> (s_axis_tready && count_q == '0))
    else $error("block not restored after digest");

endmodule

`default_nettype wire

// ----- verif/tb_md5_message_digest.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 message digest testbench
// Sends byte and finish transfers into the digest block and checks each
// digest word against a behavioral MD5 engine kept in the bench. Known
// digests are typed in for the empty message and "abc". Random messages
// follow, some with lengths drawn from the padding boundaries. Both stream
// sides insert random idle cycles.
// ----------------------------------------------------------------------------
module tb_md5_message_digest;
  import md5_pkg::*;

  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned TIMEOUT_CYCLES = 400_000;
  localparam int unsigned RANDOM_ITEMS   = 280;
  localparam int unsigned SETTLE_CYCLES  = 300;

  // MD5 initial chaining words, A in the lowest slot.
  localparam logic [3:0][31:0] CHAIN_INIT = {
    32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  // Additive constant of each of the 64 rounds.
  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Left-rotate amounts, four per round group.
  localparam int ROT_AMT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  // Well-known digests, word A in the lowest slot.
  localparam logic [3:0][31:0] EMPTY_DIGEST = {
    32'h7e42f8ec, 32'h980980e9, 32'h04b2008f, 32'hd98c1dd4
  };
  localparam logic [3:0][31:0] ABC_DIGEST = {
    32'h727fe128, 32'h7d3f96d6, 32'hb04fd23c, 32'h98500190
  };
  localparam logic [3:0][31:0] NO_DIGEST = '0;

  // Lengths that sit on the padding and block boundaries.
  localparam int EDGE_LENGTHS [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

  // One row of the directed table; known is set where the digest is typed in.
  typedef struct packed {
    logic             kind;
    logic [7:0]       data;
    logic             known;
    logic [3:0][31:0] digest;
  } stim_row_t;

  localparam int unsigned DIRECTED_LEN = 13;
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    '{KIND_FINISH, 8'hff, 1'b1, EMPTY_DIGEST},  // empty message, data ignored
    '{KIND_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},  // back-to-back empty message
    '{KIND_BYTE,   8'h61, 1'b0, NO_DIGEST},
    '{KIND_BYTE,   8'h62, 1'b0, NO_DIGEST},
    '{KIND_BYTE,   8'h63, 1'b0, NO_DIGEST},
    '{KIND_FINISH, 8'h5a, 1'b1, ABC_DIGEST},
    '{KIND_BYTE,   8'h00, 1'b0, NO_DIGEST},
    '{KIND_BYTE,   8'hff, 1'b0, NO_DIGEST},
    '{KIND_BYTE,   8'h80, 1'b0, NO_DIGEST},
    '{KIND_BYTE,   8'h7f, 1'b0, NO_DIGEST},
    '{KIND_BYTE,   8'h01, 1'b0, NO_DIGEST},
    '{KIND_BYTE,   8'hfe, 1'b0, NO_DIGEST},
    '{KIND_FINISH, 8'ha5, 1'b0, NO_DIGEST}
  };

  // One digest word as it appears on the output stream.
  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  index;
    logic        last;
  } digest_beat_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tuser  = KIND_BYTE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Bench copy of the hash state.
  logic [3:0][31:0] md5_chain;
  logic [7:0]       md5_block [64];
  logic [60:0]      md5_nbytes;

  digest_beat_t pending_digest_q [$];
  int unsigned  mismatch_count;
  int unsigned  accepted_items;
  int unsigned  stall_left;
  int unsigned  calm_left;

  md5_message_digest uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Free-running clock.
  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Start of a new message: initial chaining words and a zero count.
  function automatic void md5_restart();
    md5_chain  = CHAIN_INIT;
    md5_nbytes = '0;
  endfunction

  // Fold the 64-byte block into the chaining words.
  function automatic void md5_compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t, nb;
    int          i, grp, idx, s;
    for (i = 0; i < 16; i++) begin
      w[i] = {md5_block[4*i+3], md5_block[4*i+2], md5_block[4*i+1], md5_block[4*i]};
    end
    a = md5_chain[0];
    b = md5_chain[1];
    c = md5_chain[2];
    d = md5_chain[3];
    for (i = 0; i < 64; i++) begin
      grp = i / 16;
      case (grp)
        0: begin
          f   = (b & c) | (~b & d);
          idx = i;
        end
        1: begin
          f   = (b & d) | (c & ~d);
          idx = (5 * i + 1) % 16;
        end
        2: begin
          f   = b ^ c ^ d;
          idx = (3 * i + 5) % 16;
        end
        default: begin
          f   = c ^ (b | ~d);
          idx = (7 * i) % 16;
        end
      endcase
      s  = ROT_AMT[grp * 4 + i % 4];
      t  = a + f + w[idx] + ROUND_K[i];
      nb = b + ((t << s) | (t >> (32 - s)));
      a  = d;
      d  = c;
      c  = b;
      b  = nb;
    end
    md5_chain[0] = md5_chain[0] + a;
    md5_chain[1] = md5_chain[1] + b;
    md5_chain[2] = md5_chain[2] + c;
    md5_chain[3] = md5_chain[3] + d;
  endfunction

  // Append one message byte; a full block is compressed at once.
  function automatic void md5_absorb_byte(input logic [7:0] data);
    md5_block[md5_nbytes[5:0]] = data;
    md5_nbytes = md5_nbytes + 61'd1;
    if (md5_nbytes[5:0] == 6'd0) begin
      md5_compress_block();
    end
  endfunction

  // Pad, append the bit length and return the digest; then restart.
  function automatic void md5_finish_message(output logic [3:0][31:0] digest);
    int          used, j;
    logic [63:0] bit_len;
    used = int'(md5_nbytes[5:0]);
    md5_block[used] = 8'h80;
    used++;
    // The length field no longer fits: pad out and compress an extra block.
    if (used > 56) begin
      for (j = used; j < 64; j++) md5_block[j] = 8'h00;
      md5_compress_block();
      used = 0;
    end
    for (j = used; j < 56; j++) md5_block[j] = 8'h00;
    bit_len = {md5_nbytes, 3'b000};
    for (j = 0; j < 8; j++) md5_block[56 + j] = bit_len[8*j +: 8];
    md5_compress_block();
    digest = md5_chain;
    md5_restart();
  endfunction

  // Drive one input transfer, after a random gap unless no_gap is set, then update the bench state.
  task automatic send_item(input logic kind, input logic [7:0] data, input bit no_gap,
                           input bit use_known, input logic [3:0][31:0] known);
    int unsigned      gap;
    logic [3:0][31:0] digest;
    digest_beat_t     beat;
    gap = no_gap ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    accepted_items++;
    if (kind == KIND_BYTE) begin
      md5_absorb_byte(data);
    end else begin
      md5_finish_message(digest);
      if (use_known) digest = known;
      for (int j = 0; j < 4; j++) begin
        beat.word  = digest[j];
        beat.index = 2'(j);
        beat.last  = (j == 3);
        pending_digest_q.push_back(beat);
      end
    end
  endtask

  // Hold off until every expected digest word has been transferred.
  task automatic wait_for_digests();
    s_axis_tvalid <= 1'b0;
    while (pending_digest_q.size() != 0) @(posedge clk_i);
  endtask

  // Compare one output transfer with the oldest expected digest word.
  function automatic void check_digest_beat();
    digest_beat_t exp_beat;
    if (pending_digest_q.size() == 0) begin
      $error("unexpected digest transfer: word %h index %0d last %0b",
             m_axis_tdata, m_axis_tuser, m_axis_tlast);
      mismatch_count++;
    end else begin
      exp_beat = pending_digest_q.pop_front();
      if (m_axis_tdata !== exp_beat.word) begin
        $error("digest_word: expected %h, actual %h", exp_beat.word, m_axis_tdata);
        mismatch_count++;
      end
      if (m_axis_tuser !== exp_beat.index) begin
        $error("word_index: expected %0d, actual %0d", exp_beat.index, m_axis_tuser);
        mismatch_count++;
      end
      if (m_axis_tlast !== exp_beat.last) begin
        $error("last_word: expected %0b, actual %0b", exp_beat.last, m_axis_tlast);
        mismatch_count++;
      end
    end
  endfunction

  // Digest sink: checks each transfer, then stalls for a random number of cycles.
  // Now and then a calm stretch takes words back to back.
  always @(posedge clk_i or negedge rst_ni) begin : digest_sink
    int unsigned draw;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
      calm_left     <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      check_digest_beat();
      if (calm_left != 0) begin
        draw = 0;
        calm_left <= calm_left - 1;
      end else begin
        draw = $urandom_range(0, 15);
        if ($urandom_range(0, 7) == 0) calm_left <= $urandom_range(4, 12);
      end
      stall_left    <= draw;
      m_axis_tready <= (draw == 0);
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Main sequence: reset, directed table, random messages, final drain.
  initial begin : stimulus
    int unsigned msg_len;
    bit          burst;
    mismatch_count = 0;
    accepted_items = 0;
    md5_restart();
    for (int j = 0; j < 64; j++) md5_block[j] = 8'h00;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    for (int r = 0; r < DIRECTED_LEN; r++) begin
      send_item(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].data, 1'b0,
                DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].digest);
    end
    wait_for_digests();

    // Random messages: mostly short, some on the padding boundaries.
    accepted_items = 0;
    while (accepted_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        msg_len = EDGE_LENGTHS[$urandom_range(0, 8)];
      end else begin
        msg_len = $urandom_range(0, 24);
      end
      burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) wait_for_digests();
      for (int unsigned n = 0; n < msg_len; n++) begin
        send_item(KIND_BYTE, 8'($urandom), burst, 1'b0, NO_DIGEST);
      end
      send_item(KIND_FINISH, 8'($urandom), burst, 1'b0, NO_DIGEST);
    end

    // Drain, then watch for stray transfers.
    wait_for_digests();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timeout waiting for the digest block");
    $display("Verification failed");
    $finish;
  end

endmodule
